// ===== sv/bdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared types and constants of the button debounce and click counter.
// ----------------------------------------------------------------------------
package bdc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int GROUP_WIDTH = 8;
	localparam int TIME_WIDTH  = 32;

	localparam int IN_BITS   = 1 + TIME_WIDTH + 3;
	localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = 3 + COUNT_WIDTH + GROUP_WIDTH + TIME_WIDTH + 2;
	localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

	localparam int ADDR_WIDTH = 5;

	typedef enum logic [2:0] {
		REG_INVERT   = 3'd0,
		REG_MODE     = 3'd1,
		REG_DEBOUNCE = 3'd2,
		REG_GAP      = 3'd3,
		REG_LONG_MIN = 3'd4,
		REG_LONG_MAX = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_RISE    = 2'd0,
		MODE_FALL    = 2'd1,
		MODE_BOTH    = 2'd2,
		MODE_NONE    = 2'd3
	} count_mode_t;

	typedef struct packed {
		logic                  invert_input;
		count_mode_t           count_mode;
		logic [TIME_WIDTH-1:0] debounce_ms;
		logic [TIME_WIDTH-1:0] press_gap_ms;
		logic [TIME_WIDTH-1:0] long_min_ms;
		logic [TIME_WIDTH-1:0] long_max_ms;
	} bdc_cfg_t;

	typedef struct packed {
		logic                  clear_length;
		logic                  clear_presses;
		logic                  clear_count;
		logic [TIME_WIDTH-1:0] now_ms;
		logic                  raw_level;
	} bdc_in_t;

	typedef struct packed {
		logic                   long_released;
		logic                   long_held;
		logic [TIME_WIDTH-1:0]  press_length;
		logic [GROUP_WIDTH-1:0] press_group;
		logic [COUNT_WIDTH-1:0] edge_count;
		logic                   fell;
		logic                   rose;
		logic                   debounced_pressed;
	} bdc_out_t;

endpackage

// ===== sv/button_debounce_click_counter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_click_counter_top
// Button debouncer with edge counter, multi-click grouping and long press.
//
// Samples arrive on the s_axis stream, one transfer per tick, each carrying
// the raw pin level, a millisecond timestamp and three clear flags. Every
// sample yields exactly one result transfer on m_axis.
// An accepted sample is registered in the input register, processed by the
// combinational core and its result is registered in the result register.
// Throughput: one sample per cycle; the state update is a single pass of
// subtractions and compares between the input and result registers.
// When m_axis_tready is low the result register holds, the input register
// still takes one more sample, then s_axis_tready drops until space frees.
// Reset: registers take their default values, the button reads as released
// at time 0, all counters clear and both stream registers empty.
// Registers sit on the APB port at byte addresses 0, 4, ... 20; the user must
// write them only while the stream is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module button_debounce_click_counter_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bdc_pkg::ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// raw_level, now_ms[31:0], clear_count, clear_presses, clear_length, zero pad
	input  logic [bdc_pkg::IN_TDATA-1:0]   s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// debounced_pressed, rose, fell, edge_count[15:0], press_group[7:0],
	// press_length[31:0], long_held, long_released, zero pad
	output logic [bdc_pkg::OUT_TDATA-1:0]  m_axis_tdata
);
	import bdc_pkg::*;

	bdc_cfg_t cfg;
	bdc_in_t  item_s1;
	logic     valid_s1;
	bdc_out_t res;
	bdc_out_t res_s2;
	logic     valid_s2;
	logic     adv;

	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	bdc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bdc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.cfg    (cfg),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= s_axis_tdata[IN_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OUT_TDATA - OUT_BITS){1'b0}}, res_s2};

endmodule

// ===== sv/bdc_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_regs
// APB configuration registers: invert, count mode and the four time limits.
// ----------------------------------------------------------------------------
module bdc_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bdc_pkg::ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output bdc_pkg::bdc_cfg_t              cfg
);
	import bdc_pkg::*;

	bdc_cfg_t cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_WIDTH-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.invert_input <= 1'b1;
			cfg_q.count_mode   <= MODE_RISE;
			cfg_q.debounce_ms  <= 32'd50;
			cfg_q.press_gap_ms <= 32'd500;
			cfg_q.long_min_ms  <= 32'd1000;
			cfg_q.long_max_ms  <= 32'hFFFF_FFFF;
		end else if (wr_en) begin
			case (idx)
				REG_INVERT:   cfg_q.invert_input <= pwdata[0];
				REG_MODE:     cfg_q.count_mode   <= count_mode_t'(pwdata[1:0]);
				REG_DEBOUNCE: cfg_q.debounce_ms  <= pwdata;
				REG_GAP:      cfg_q.press_gap_ms <= pwdata;
				REG_LONG_MIN: cfg_q.long_min_ms  <= pwdata;
				REG_LONG_MAX: cfg_q.long_max_ms  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_INVERT:   prdata = {31'd0, cfg_q.invert_input};
			REG_MODE:     prdata = {30'd0, cfg_q.count_mode};
			REG_DEBOUNCE: prdata = cfg_q.debounce_ms;
			REG_GAP:      prdata = cfg_q.press_gap_ms;
			REG_LONG_MIN: prdata = cfg_q.long_min_ms;
			REG_LONG_MAX: prdata = cfg_q.long_max_ms;
			default:      prdata = 32'd0;
		endcase
	end

endmodule

// ===== sv/bdc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_core
// Debounce state, edge counter, click grouping and press length; one sample
// is processed per enabled cycle.
// ----------------------------------------------------------------------------
module bdc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  bdc_pkg::bdc_cfg_t cfg,
	input  bdc_pkg::bdc_in_t  item,
	output bdc_pkg::bdc_out_t res
);
	import bdc_pkg::*;

	logic                   last_raw_q;
	logic [TIME_WIDTH-1:0]  last_change_q;
	logic                   debounced_q;
	logic [COUNT_WIDTH-1:0] edge_total_q;
	logic [GROUP_WIDTH-1:0] group_q;
	logic [TIME_WIDTH-1:0]  press_start_q;
	logic [TIME_WIDTH-1:0]  stored_q;

	logic                   level;
	logic                   changed;
	logic [TIME_WIDTH-1:0]  change_n;
	logic [TIME_WIDTH-1:0]  steady;
	logic                   flip;
	logic                   rose;
	logic                   fell;
	logic                   deb_n;
	logic [TIME_WIDTH-1:0]  since_old;
	logic [TIME_WIDTH-1:0]  since_n;
	logic                   count_it;
	logic [COUNT_WIDTH-1:0] edge_n;
	logic [GROUP_WIDTH-1:0] group_n;
	logic [TIME_WIDTH-1:0]  start_n;
	logic [TIME_WIDTH-1:0]  stored_n;
	logic                   group_ready;
	logic [TIME_WIDTH-1:0]  len;
	logic                   in_window;

	always_comb begin
		level     = item.raw_level ^ cfg.invert_input;
		changed   = level != last_raw_q;
		change_n  = changed ? item.now_ms : last_change_q;
		steady    = item.now_ms - change_n;
		flip      = (cfg.debounce_ms < steady) && (level != debounced_q);
		rose      = flip && level;
		fell      = flip && !level;
		deb_n     = flip ? level : debounced_q;
		since_old = item.now_ms - press_start_q;
		since_n   = rose ? '0 : since_old;
		start_n   = rose ? item.now_ms : press_start_q;

		case (cfg.count_mode)
			MODE_RISE: count_it = rose;
			MODE_FALL: count_it = fell;
			MODE_BOTH: count_it = flip;
			default:   count_it = 1'b0;
		endcase
		edge_n = edge_total_q + COUNT_WIDTH'(count_it);

		if (rose) begin
			group_n = (since_old < cfg.press_gap_ms) ? group_q + GROUP_WIDTH'(1)
			                                         : GROUP_WIDTH'(1);
		end else begin
			group_n = group_q;
		end

		if (rose) begin
			stored_n = '0;
		end else if (fell) begin
			stored_n = since_old;
		end else begin
			stored_n = stored_q;
		end

		group_ready = since_n > cfg.press_gap_ms;
		len         = deb_n ? since_n : stored_n;
		in_window   = (cfg.long_min_ms < len) && (len <= cfg.long_max_ms);

		res.debounced_pressed = deb_n;
		res.rose              = rose;
		res.fell              = fell;
		res.edge_count        = edge_n;
		res.press_group       = group_ready ? group_n : '0;
		res.press_length      = len;
		res.long_held         = deb_n && in_window;
		res.long_released     = !deb_n && in_window;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q    <= 1'b0;
			last_change_q <= '0;
			debounced_q   <= 1'b0;
			edge_total_q  <= '0;
			group_q       <= '0;
			press_start_q <= '0;
			stored_q      <= '0;
		end else if (en) begin
			last_raw_q    <= level;
			last_change_q <= change_n;
			debounced_q   <= deb_n;
			edge_total_q  <= item.clear_count ? '0 : edge_n;
			group_q       <= (item.clear_presses && group_ready) ? '0 : group_n;
			press_start_q <= start_n;
			stored_q      <= item.clear_length ? '0 : stored_n;
		end
	end

endmodule
